// ----- hw/rtl/tfd_pkg.sv -----
package tfd_pkg;

  localparam int KEPT_PAYLOAD_BYTES_DEF = 12;
  // payload bytes that any kind decodes
  localparam int USED_PAYLOAD_BYTES = 12;

  localparam logic [7:0] SYNC_BYTE = 8'hEE;
  localparam logic [7:0] TAIL_BYTE = 8'hFF;

  localparam logic [7:0] KIND_ATTITUDE = 8'h00;
  localparam logic [7:0] KIND_POSITION = 8'h01;
  localparam logic [7:0] KIND_BATTERY  = 8'h02;
  localparam logic [7:0] KIND_ID       = 8'h03;
  localparam logic [7:0] KIND_LAST     = 8'h07;

  localparam logic [7:0] NEED_ATTITUDE = 8'd6;
  localparam logic [7:0] NEED_POSITION = 8'd12;
  localparam logic [7:0] NEED_BYTE     = 8'd1;
  localparam logic [7:0] NEED_PID      = 8'd3;

  localparam logic [2:0] OUT_APPLIED   = 3'd0;
  localparam logic [2:0] OUT_CHECKSUM  = 3'd1;
  localparam logic [2:0] OUT_TAIL      = 3'd2;
  localparam logic [2:0] OUT_KIND      = 3'd3;
  localparam logic [2:0] OUT_SHORT     = 3'd4;

  typedef struct packed {
    logic [2:0]                          outcome;
    logic [7:0]                          kind;
    logic [USED_PAYLOAD_BYTES*8-1:0]     payload;
  } tfd_frame_t;

  function automatic logic [7:0] needed_length(input logic [7:0] kind);
    logic [7:0] need;
    if (kind == KIND_ATTITUDE) begin
      need = NEED_ATTITUDE;
    end else if (kind == KIND_POSITION) begin
      need = NEED_POSITION;
    end else if (kind == KIND_BATTERY || kind == KIND_ID) begin
      need = NEED_BYTE;
    end else begin
      need = NEED_PID;
    end
    return need;
  endfunction

endpackage

// ----- hw/rtl/tfd_front.sv -----
module tfd_front #(
  parameter int KEPT_PAYLOAD_BYTES = tfd_pkg::KEPT_PAYLOAD_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               push_valid,
  input  logic               push_ready,
  output tfd_pkg::tfd_frame_t push_frame
);
  import tfd_pkg::*;

  localparam int IDX_W = $clog2(KEPT_PAYLOAD_BYTES);

  localparam logic [2:0] PH_HUNT1   = 3'd0;
  localparam logic [2:0] PH_HUNT2   = 3'd1;
  localparam logic [2:0] PH_KIND    = 3'd2;
  localparam logic [2:0] PH_LEN     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CHECK   = 3'd5;
  localparam logic [2:0] PH_TAIL    = 3'd6;

  logic [2:0] phase, phase_next;
  logic [7:0] frame_kind;
  logic [7:0] frame_length;
  logic [7:0] bytes_seen;
  logic [7:0] running_sum;
  logic [7:0] store [KEPT_PAYLOAD_BYTES];
  logic       take;
  logic [7:0] seen_inc;

  // only the tail byte needs room in the queue
  assign in_ready   = (phase != PH_TAIL) || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = in_valid && (phase == PH_TAIL);
  assign seen_inc   = bytes_seen + 8'd1;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HUNT1:   if (rx_byte == SYNC_BYTE) phase_next = PH_HUNT2;
      PH_HUNT2:   phase_next = (rx_byte == SYNC_BYTE) ? PH_KIND : PH_HUNT1;
      PH_KIND:    phase_next = PH_LEN;
      PH_LEN:     phase_next = (rx_byte == 8'h00) ? PH_CHECK : PH_PAYLOAD;
      PH_PAYLOAD: if (seen_inc == frame_length) phase_next = PH_CHECK;
      PH_CHECK:   phase_next = PH_TAIL;
      PH_TAIL:    phase_next = PH_HUNT1;
      default:    phase_next = PH_HUNT1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT1;
      frame_kind   <= 8'h00;
      frame_length <= 8'h00;
      bytes_seen   <= 8'h00;
      running_sum  <= 8'h00;
    end else if (take) begin
      phase <= phase_next;
      unique case (phase)
        PH_KIND: begin
          frame_kind  <= rx_byte;
          running_sum <= rx_byte;
        end
        PH_LEN: begin
          frame_length <= rx_byte;
          running_sum  <= running_sum + rx_byte;
          bytes_seen   <= 8'h00;
        end
        PH_PAYLOAD: begin
          running_sum <= running_sum + rx_byte;
          bytes_seen  <= seen_inc;
        end
        PH_CHECK: running_sum <= running_sum ^ rx_byte;
        default: ;
      endcase
    end
  end

  // drop bytes past the kept window, they only feed the sum
  always_ff @(posedge clk) begin
    if (take && phase == PH_PAYLOAD && bytes_seen < 8'(KEPT_PAYLOAD_BYTES)) begin
      store[bytes_seen[IDX_W-1:0]] <= rx_byte;
    end
  end

  always_comb begin
    priority if (running_sum != 8'h00) begin
      push_frame.outcome = OUT_CHECKSUM;
    end else if (rx_byte != TAIL_BYTE) begin
      push_frame.outcome = OUT_TAIL;
    end else if (frame_kind > KIND_LAST) begin
      push_frame.outcome = OUT_KIND;
    end else if (frame_length < needed_length(frame_kind)) begin
      push_frame.outcome = OUT_SHORT;
    end else begin
      push_frame.outcome = OUT_APPLIED;
    end
    push_frame.kind = frame_kind;
    for (int i = 0; i < USED_PAYLOAD_BYTES; i++) begin
      push_frame.payload[i*8 +: 8] = store[i];
    end
  end

  a_tail_waits: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TAIL && !push_ready) |-> !in_ready)
    else $error("tail byte taken with queue full");
  a_tail_pushes: assert property (@(posedge clk) disable iff (rst)
    take && phase == PH_TAIL |-> push_valid && push_ready)
    else $error("tail byte taken without push");
  a_short_frame: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_seen < frame_length))
    else $error("payload count ran past length");

endmodule

// ----- hw/rtl/tfd_queue.sv -----
module tfd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  tfd_pkg::tfd_frame_t push_frame,
  output logic                pop_valid,
  input  logic                pop_ready,
  output tfd_pkg::tfd_frame_t pop_frame
);
  import tfd_pkg::*;

  tfd_frame_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_frame  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_frame;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("queue count missed a push");

endmodule

// ----- hw/rtl/tfd_back.sv -----
module tfd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  tfd_pkg::tfd_frame_t pop_frame,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          outcome,
  output logic [7:0]          record_kind,
  output logic signed [31:0]  value_a,
  output logic signed [31:0]  value_b,
  output logic signed [31:0]  value_c
);
  import tfd_pkg::*;

  logic [7:0]  pl [USED_PAYLOAD_BYTES];
  logic [31:0] dec_a, dec_b, dec_c;
  logic        load;

  assign load      = pop_valid && (!out_valid || out_ready);
  assign pop_ready = !out_valid || out_ready;

  always_comb begin
    for (int i = 0; i < USED_PAYLOAD_BYTES; i++) begin
      pl[i] = pop_frame.payload[i*8 +: 8];
    end
    dec_a = 32'h0;
    dec_b = 32'h0;
    dec_c = 32'h0;
    if (pop_frame.outcome == OUT_APPLIED) begin
      priority if (pop_frame.kind == KIND_ATTITUDE) begin
        dec_a = {{16{pl[0][7]}}, pl[0], pl[1]};
        dec_b = {{16{pl[2][7]}}, pl[2], pl[3]};
        dec_c = {{16{pl[4][7]}}, pl[4], pl[5]};
      end else if (pop_frame.kind == KIND_POSITION) begin
        dec_a = {pl[0], pl[1], pl[2], pl[3]};
        dec_b = {pl[4], pl[5], pl[6], pl[7]};
        dec_c = {pl[8], pl[9], pl[10], pl[11]};
      end else if (pop_frame.kind == KIND_BATTERY || pop_frame.kind == KIND_ID) begin
        dec_a = {24'h0, pl[0]};
      end else begin
        dec_a = {24'h0, pl[0]};
        dec_b = {24'h0, pl[1]};
        dec_c = {24'h0, pl[2]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      outcome     <= pop_frame.outcome;
      record_kind <= pop_frame.kind;
      value_a     <= dec_a;
      value_b     <= dec_b;
      value_c     <= dec_c;
    end
  end

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome != OUT_APPLIED |->
      value_a == 32'sd0 && value_b == 32'sd0 && value_c == 32'sd0)
    else $error("error transaction carries values");

endmodule

// ----- hw/rtl/telemetry_frame_deframer.sv -----
// Telemetry frame deframer.
// Input channel: one received byte per transaction on rx_byte (in_valid /
// in_ready). The block hunts for the sync pair 0xEE 0xEE, then takes kind,
// length, payload, an 8-bit additive checksum and a 0xFF tail.
// Output channel: one transaction per frame, at its tail byte (out_valid /
// out_ready): outcome, record_kind and up to three decoded values; on any
// error outcome the values are zero.
// Throughput: one byte per cycle. The front takes every non-tail byte at
// once; a tail byte waits only while the two-entry frame queue is full.
// Result path: the frame is written into the queue when its tail byte is
// taken, then the output register loads it from the queue.
// Receiver stall: finished frames collect in the queue and output register;
// with both full the front holds in_ready low on the next tail byte only.
// Reset: rst (synchronous) returns to hunting the first sync byte and
// empties the queue and output register; a partial frame is lost.
module telemetry_frame_deframer #(
  parameter int KEPT_PAYLOAD_BYTES = tfd_pkg::KEPT_PAYLOAD_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         outcome,
  output logic [7:0]         record_kind,
  output logic signed [31:0] value_a,
  output logic signed [31:0] value_b,
  output logic signed [31:0] value_c
);
  import tfd_pkg::*;

  logic       push_valid;
  logic       push_ready;
  tfd_frame_t push_frame;
  logic       pop_valid;
  logic       pop_ready;
  tfd_frame_t pop_frame;

  tfd_front #(
    .KEPT_PAYLOAD_BYTES(KEPT_PAYLOAD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame)
  );

  tfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_frame  (pop_frame)
  );

  tfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_frame   (pop_frame),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .outcome     (outcome),
    .record_kind (record_kind),
    .value_a     (value_a),
    .value_b     (value_b),
    .value_c     (value_c)
  );

endmodule
